// ===== hdl/dafs_pkg.sv =====
// shared types, constants and register codes of the daily alarm feed scheduler
`timescale 1ns / 1ps

package dafs_pkg;

  // field widths
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned DAY_W   = 27;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned SEC_W   = 16;
  localparam int unsigned MASK_W  = 7;
  localparam int unsigned FLAG_W  = 4;
  localparam int unsigned LIMIT_W = 26;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 27;

  // number of daily time slots
  localparam int unsigned FEED_SLOTS = 4;

  // time constants
  localparam logic [DAY_W-1:0] DAY_MS   = 27'd86400000;
  localparam logic [DAY_W-1:0] DAY_MAX  = 27'd86399999;
  localparam logic [9:0]       MS_PER_S = 10'd1000;

  // legal slot count range
  localparam logic [CNT_W-1:0] FEED_COUNT_MIN = 3'd1;
  localparam logic [CNT_W-1:0] FEED_COUNT_MAX = 3'd4;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_FEED_COUNT   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_TIME_ONE     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_TIME_TWO     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_TIME_THREE   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_TIME_FOUR    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_FEED_SECONDS = 3'd5;
  localparam logic [CIDX_W-1:0] REG_WEEKDAY_MASK = 3'd6;
  localparam logic [CIDX_W-1:0] REG_MODE_FLAGS   = 3'd7;

  // mode flag bit positions
  localparam int unsigned FLAG_SCHED_EN = 0;
  localparam int unsigned FLAG_LIGHT_ON = 1;
  localparam int unsigned FLAG_CAL_EN   = 2;
  localparam int unsigned FLAG_AUTO_LT  = 3;

  // register reset values
  localparam logic [CNT_W-1:0]   RST_FEED_COUNT = 3'd2;
  localparam logic [DAY_W-1:0]   RST_TIME_ONE   = 27'd25200000;
  localparam logic [DAY_W-1:0]   RST_TIME_TWO   = 27'd68400000;
  localparam logic [DAY_W-1:0]   RST_TIME_THREE = 27'd43200000;
  localparam logic [DAY_W-1:0]   RST_TIME_FOUR  = 27'd61200000;
  localparam logic [LIMIT_W-1:0] RST_LIMIT      = 26'd2000;
  localparam logic [MASK_W-1:0]  RST_MASK       = 7'd63;
  localparam logic [FLAG_W-1:0]  RST_FLAGS      = 4'd13;

  // result of the wait computation
  typedef struct packed {
    logic             update;
    logic [DAY_W-1:0] wait_ms;
  } wait_t;

  // clamp a time of day to the last millisecond of the day
  function automatic logic [DAY_W-1:0] clamp_day(input logic [DAY_W-1:0] v);
    clamp_day = (v > DAY_MAX) ? DAY_MAX : v;
  endfunction

endpackage

// ===== hdl/dafs_wait.sv =====
// wait length up to the next daily feeding time
`timescale 1ns / 1ps

module dafs_wait (
  input  logic [dafs_pkg::CNT_W-1:0] feed_count,
  input  logic [dafs_pkg::DAY_W-1:0] feed_time [dafs_pkg::FEED_SLOTS],
  input  logic [dafs_pkg::DAY_W-1:0] day_ms,
  output dafs_pkg::wait_t            res
);

  // first slot strictly after now, else tomorrow's first slot
  always_comb begin
    logic [dafs_pkg::DAY_W-1:0] d;
    logic                       found;
    logic [dafs_pkg::DAY_W-1:0] pick;
    logic [dafs_pkg::DAY_W:0]   wrap;
    d     = dafs_pkg::clamp_day(day_ms);
    found = 1'b0;
    pick  = '0;
    for (int i = 0; i < dafs_pkg::FEED_SLOTS; i++) begin
      if (!found && (dafs_pkg::CNT_W'(i) < feed_count) && (feed_time[i] > d)) begin
        found = 1'b1;
        pick  = feed_time[i] - d;
      end
    end
    wrap = {1'b0, dafs_pkg::DAY_MS} - {1'b0, d} + {1'b0, feed_time[0]};
    res.update  = (feed_count >= dafs_pkg::FEED_COUNT_MIN) &&
                  (feed_count <= dafs_pkg::FEED_COUNT_MAX);
    res.wait_ms = found ? pick : wrap[dafs_pkg::DAY_W-1:0];
  end

endmodule

// ===== hdl/daily_alarm_feed_scheduler.sv =====
// top level of the daily alarm feed scheduler
`timescale 1ns / 1ps

// One item is one millisecond tick (free-running count, time of day, weekday)
// and yields exactly one result item. An accepted item sits in an input
// register, is evaluated against the scheduler state combinationally and
// moves into a result register once that register is empty or being read,
// so one item can be accepted on every clock while the result side keeps up.
// in_stall rises only when the result register is still held by out_stall
// and the input register is full. Daily times are clamped to
// the last millisecond of the day when written, and the feeding length in
// milliseconds is formed at the write of feed_seconds. Configuration is
// always ready and must be written only while no item is in flight.
module daily_alarm_feed_scheduler (
  input  logic                        clk,
  input  logic                        rst_n,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dafs_pkg::NOW_W-1:0]  in_now_ms,
  input  logic [dafs_pkg::DAY_W-1:0]  in_day_ms,
  input  logic [dafs_pkg::WDAY_W-1:0] in_weekday,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_servo_on,
  output logic                        out_light_on,
  output logic                        out_feed_started,
  output logic                        out_feed_finished,
  output logic [dafs_pkg::DAY_W-1:0]  out_wait_left,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dafs_pkg::CIDX_W-1:0] cfg_index,
  input  logic [dafs_pkg::CDAT_W-1:0] cfg_data
);

  // configuration registers
  logic [dafs_pkg::CNT_W-1:0]   feed_count_r;
  logic [dafs_pkg::DAY_W-1:0]   feed_time_r [dafs_pkg::FEED_SLOTS];
  logic [dafs_pkg::LIMIT_W-1:0] feed_limit_r;
  logic [dafs_pkg::MASK_W-1:0]  weekday_mask_r;
  logic [dafs_pkg::FLAG_W-1:0]  mode_flags_r;

  // scheduler state
  logic [dafs_pkg::NOW_W-1:0] mark_r, mark_nxt;
  logic [dafs_pkg::DAY_W-1:0] wait_r, wait_nxt;
  logic [dafs_pkg::NOW_W-1:0] start_r, start_nxt;
  logic                       feeding_r, feeding_nxt;
  logic                       sched_valid_r;
  logic                       light_r, light_nxt;

  // input register
  logic                        s1_valid_r, s1_valid_nxt;
  logic [dafs_pkg::NOW_W-1:0]  s1_now_r;
  logic [dafs_pkg::DAY_W-1:0]  s1_day_r;
  logic [dafs_pkg::WDAY_W-1:0] s1_wday_r;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_servo_r, out_light_r, out_started_r, out_finished_r;
  logic [dafs_pkg::DAY_W-1:0] out_wait_r;

  logic            in_accept;
  logic            advance;
  logic            cfg_write;
  logic            started;
  logic            finished;
  dafs_pkg::wait_t wres;

  // handshake
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // wait computation
  dafs_wait u_wait (
    .feed_count (feed_count_r),
    .feed_time  (feed_time_r),
    .day_ms     (s1_day_r),
    .res        (wres)
  );

  // per-tick evaluation
  always_comb begin
    logic [dafs_pkg::NOW_W-1:0] elapsed;
    logic [dafs_pkg::NOW_W-1:0] run_ms;
    logic [7:0]                 mask_ext;
    logic                       trig;
    logic                       allowed;
    logic                       auto_lt;
    elapsed  = s1_now_r - mark_r;
    run_ms   = s1_now_r - start_r;
    mask_ext = {1'b1, weekday_mask_r};
    auto_lt  = mode_flags_r[dafs_pkg::FLAG_AUTO_LT];
    trig     = sched_valid_r && mode_flags_r[dafs_pkg::FLAG_SCHED_EN] &&
               (elapsed > {5'd0, wait_r});
    allowed  = !(mode_flags_r[dafs_pkg::FLAG_CAL_EN] && !mask_ext[s1_wday_r]);

    mark_nxt  = mark_r;
    wait_nxt  = wait_r;
    start_nxt = start_r;
    light_nxt = light_r;
    started   = 1'b0;

    if (!sched_valid_r || trig) begin
      mark_nxt = s1_now_r - 32'd1;
      if (wres.update) begin
        wait_nxt = wres.wait_ms;
      end
    end
    if (trig && allowed) begin
      started   = 1'b1;
      start_nxt = s1_now_r;
      if (auto_lt) begin
        light_nxt = 1'b1;
      end
    end

    // a feeding never ends on the tick it starts
    finished    = feeding_r && !started && (run_ms > {6'd0, feed_limit_r});
    feeding_nxt = started ? 1'b1 : (finished ? 1'b0 : feeding_r);
    if (finished && auto_lt && !mode_flags_r[dafs_pkg::FLAG_LIGHT_ON]) begin
      light_nxt = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      feed_count_r   <= dafs_pkg::RST_FEED_COUNT;
      feed_time_r[0] <= dafs_pkg::RST_TIME_ONE;
      feed_time_r[1] <= dafs_pkg::RST_TIME_TWO;
      feed_time_r[2] <= dafs_pkg::RST_TIME_THREE;
      feed_time_r[3] <= dafs_pkg::RST_TIME_FOUR;
      feed_limit_r   <= dafs_pkg::RST_LIMIT;
      weekday_mask_r <= dafs_pkg::RST_MASK;
      mode_flags_r   <= dafs_pkg::RST_FLAGS;
      mark_r         <= '0;
      wait_r         <= '0;
      start_r        <= '0;
      feeding_r      <= 1'b0;
      sched_valid_r  <= 1'b0;
      light_r        <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        case (cfg_index)
          dafs_pkg::REG_FEED_COUNT: begin
            feed_count_r  <= cfg_data[dafs_pkg::CNT_W-1:0];
            sched_valid_r <= 1'b0;
          end
          dafs_pkg::REG_TIME_ONE: begin
            feed_time_r[0] <= dafs_pkg::clamp_day(cfg_data);
            sched_valid_r  <= 1'b0;
          end
          dafs_pkg::REG_TIME_TWO: begin
            feed_time_r[1] <= dafs_pkg::clamp_day(cfg_data);
            sched_valid_r  <= 1'b0;
          end
          dafs_pkg::REG_TIME_THREE: begin
            feed_time_r[2] <= dafs_pkg::clamp_day(cfg_data);
            sched_valid_r  <= 1'b0;
          end
          dafs_pkg::REG_TIME_FOUR: begin
            feed_time_r[3] <= dafs_pkg::clamp_day(cfg_data);
            sched_valid_r  <= 1'b0;
          end
          dafs_pkg::REG_FEED_SECONDS: begin
            feed_limit_r <= {10'd0, cfg_data[dafs_pkg::SEC_W-1:0]} *
                            {16'd0, dafs_pkg::MS_PER_S};
          end
          dafs_pkg::REG_WEEKDAY_MASK: begin
            weekday_mask_r <= cfg_data[dafs_pkg::MASK_W-1:0];
          end
          dafs_pkg::REG_MODE_FLAGS: begin
            mode_flags_r <= cfg_data[dafs_pkg::FLAG_W-1:0];
            light_r      <= cfg_data[dafs_pkg::FLAG_LIGHT_ON];
          end
          default: begin
          end
        endcase
      end else if (advance) begin
        mark_r        <= mark_nxt;
        wait_r        <= wait_nxt;
        start_r       <= start_nxt;
        feeding_r     <= feeding_nxt;
        sched_valid_r <= 1'b1;
        light_r       <= light_nxt;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_now_r  <= in_now_ms;
      s1_day_r  <= in_day_ms;
      s1_wday_r <= in_weekday;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_servo_r    <= feeding_nxt;
      out_light_r    <= light_nxt;
      out_started_r  <= started;
      out_finished_r <= finished;
      out_wait_r     <= wait_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_servo_on      = out_servo_r;
  assign out_light_on      = out_light_r;
  assign out_feed_started  = out_started_r;
  assign out_feed_finished = out_finished_r;
  assign out_wait_left     = out_wait_r;

  // an evaluated item always lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("evaluated item missing from result register");

  // a start and an end never share one tick
  a_start_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_started_r && out_finished_r))
    else $error("feeding started and finished on the same tick");

  // a started feeding drives the servo
  a_start_servo: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_started_r) |-> out_servo_r)
    else $error("feeding started without servo drive");

  // the wait never exceeds one day
  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wait_r <= dafs_pkg::DAY_MS)
    else $error("wait longer than one day");

endmodule

// ===== bench/daily_alarm_feed_scheduler_tb.sv =====
// self-checking bench for the daily alarm feed scheduler: shadow schedule, random ticks, stalls
`timescale 1ns / 1ps

module daily_alarm_feed_scheduler_tb;

  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_TICKS = 105;
  localparam int unsigned RAND_PHASES = 8;
  // feeding length after reset, in seconds
  localparam logic [dafs_pkg::SEC_W-1:0] SEC_RESET = 16'd2;

  typedef struct packed {
    logic [dafs_pkg::NOW_W-1:0]  now;
    logic [dafs_pkg::DAY_W-1:0]  day;
    logic [dafs_pkg::WDAY_W-1:0] wd;
  } tick_t;

  typedef struct packed {
    logic                       servo;
    logic                       light;
    logic                       started;
    logic                       finished;
    logic [dafs_pkg::DAY_W-1:0] wait_left;
  } feed_res_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [dafs_pkg::NOW_W-1:0]  in_now_ms = '0;
  logic [dafs_pkg::DAY_W-1:0]  in_day_ms = '0;
  logic [dafs_pkg::WDAY_W-1:0] in_weekday = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_servo_on;
  logic                        out_light_on;
  logic                        out_feed_started;
  logic                        out_feed_finished;
  logic [dafs_pkg::DAY_W-1:0]  out_wait_left;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [dafs_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [dafs_pkg::CDAT_W-1:0] cfg_data = '0;

  daily_alarm_feed_scheduler uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_now_ms        (in_now_ms),
    .in_day_ms        (in_day_ms),
    .in_weekday       (in_weekday),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_servo_on     (out_servo_on),
    .out_light_on     (out_light_on),
    .out_feed_started (out_feed_started),
    .out_feed_finished(out_feed_finished),
    .out_wait_left    (out_wait_left),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // shadow copy of the registers
  logic [dafs_pkg::CNT_W-1:0]  cnt_r;
  logic [dafs_pkg::DAY_W-1:0]  time_r [dafs_pkg::FEED_SLOTS];
  logic [dafs_pkg::SEC_W-1:0]  sec_r;
  logic [dafs_pkg::MASK_W-1:0] mask_r;
  logic [dafs_pkg::FLAG_W-1:0] mode_r;

  // shadow copy of the schedule state
  logic [dafs_pkg::NOW_W-1:0]  mark_q;
  logic [dafs_pkg::NOW_W-1:0]  start_q;
  logic [dafs_pkg::DAY_W-1:0]  wait_q;
  logic                        feeding_q;
  logic                        sched_ok;
  logic                        light_q;

  tick_t       ticks_to_send [$];
  feed_res_t   due_results [$];
  int unsigned pushed_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned errors = 0;
  int unsigned cyc = 0;
  bit          in_took = 1'b0;
  bit          calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_ask = 0;
  int unsigned hold_seen = 0;
  tick_t       next_tick;

  // stimulus clock: free-running count, time of day, weekday
  logic [dafs_pkg::NOW_W-1:0] cur_now;
  int                         cur_day;
  int                         cur_wd;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [dafs_pkg::DAY_W-1:0] day_clip(
      input logic [dafs_pkg::DAY_W-1:0] v);
    return (v > dafs_pkg::DAY_MAX) ? dafs_pkg::DAY_MAX : v;
  endfunction

  // new wait up to the first daily time strictly after now, else tomorrow's first
  function automatic void recompute_wait(input logic [dafs_pkg::NOW_W-1:0] now,
                                         input logic [dafs_pkg::DAY_W-1:0] day);
    logic [dafs_pkg::DAY_W-1:0] d;
    logic [dafs_pkg::DAY_W-1:0] t;
    logic                       hit;
    d      = day_clip(day);
    mark_q = now - 1;
    if (cnt_r >= dafs_pkg::FEED_COUNT_MIN && cnt_r <= dafs_pkg::FEED_COUNT_MAX) begin
      hit = 1'b0;
      for (int i = 0; i < dafs_pkg::FEED_SLOTS; i++) begin
        t = day_clip(time_r[i]);
        if (!hit && i < cnt_r && t > d) begin
          wait_q = t - d;
          hit    = 1'b1;
        end
      end
      if (!hit) wait_q = dafs_pkg::DAY_MS - d + day_clip(time_r[0]);
    end
  endfunction

  // one millisecond tick of the scheduler
  function automatic feed_res_t step_schedule(input tick_t tk);
    feed_res_t                  r;
    logic [dafs_pkg::NOW_W-1:0] elapsed;
    logic [dafs_pkg::NOW_W-1:0] run_ms;
    logic [dafs_pkg::NOW_W-1:0] run_max;
    logic                       auto_lt;
    logic                       blocked;
    r       = '0;
    auto_lt = mode_r[dafs_pkg::FLAG_AUTO_LT];
    if (!sched_ok) begin
      recompute_wait(tk.now, tk.day);
      sched_ok = 1'b1;
    end else begin
      elapsed = tk.now - mark_q;
      if (mode_r[dafs_pkg::FLAG_SCHED_EN] && elapsed > dafs_pkg::NOW_W'(wait_q)) begin
        recompute_wait(tk.now, tk.day);
        blocked = mode_r[dafs_pkg::FLAG_CAL_EN] &&
                  ((tk.wd < 3'd7) ? !mask_r[tk.wd] : 1'b0);
        if (!blocked) begin
          start_q   = tk.now;
          feeding_q = 1'b1;
          r.started = 1'b1;
          if (auto_lt) light_q = 1'b1;
        end
      end
    end
    run_ms  = tk.now - start_q;
    run_max = dafs_pkg::NOW_W'(sec_r) * dafs_pkg::NOW_W'(dafs_pkg::MS_PER_S);
    if (feeding_q && run_ms > run_max) begin
      feeding_q  = 1'b0;
      r.finished = 1'b1;
      if (auto_lt && !mode_r[dafs_pkg::FLAG_LIGHT_ON]) light_q = 1'b0;
    end
    r.servo     = feeding_q;
    r.light     = light_q;
    r.wait_left = wait_q;
    return r;
  endfunction

  function automatic void reset_model();
    cnt_r     = dafs_pkg::RST_FEED_COUNT;
    time_r[0] = dafs_pkg::RST_TIME_ONE;
    time_r[1] = dafs_pkg::RST_TIME_TWO;
    time_r[2] = dafs_pkg::RST_TIME_THREE;
    time_r[3] = dafs_pkg::RST_TIME_FOUR;
    sec_r     = SEC_RESET;
    mask_r    = dafs_pkg::RST_MASK;
    mode_r    = dafs_pkg::RST_FLAGS;
    mark_q    = '0;
    wait_q    = '0;
    start_q   = '0;
    feeding_q = 1'b0;
    sched_ok  = 1'b0;
    light_q   = 1'b0;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // register write, shadow updated at the accepting edge
  task automatic write_reg(input logic [dafs_pkg::CIDX_W-1:0] idx,
                           input logic [dafs_pkg::CDAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dafs_pkg::REG_FEED_COUNT: begin
        cnt_r    = data[dafs_pkg::CNT_W-1:0];
        sched_ok = 1'b0;
      end
      dafs_pkg::REG_TIME_ONE, dafs_pkg::REG_TIME_TWO, dafs_pkg::REG_TIME_THREE,
      dafs_pkg::REG_TIME_FOUR: begin
        time_r[2'(idx - dafs_pkg::REG_TIME_ONE)] = data[dafs_pkg::DAY_W-1:0];
        sched_ok = 1'b0;
      end
      dafs_pkg::REG_FEED_SECONDS: sec_r  = data[dafs_pkg::SEC_W-1:0];
      dafs_pkg::REG_WEEKDAY_MASK: mask_r = data[dafs_pkg::MASK_W-1:0];
      dafs_pkg::REG_MODE_FLAGS: begin
        mode_r  = data[dafs_pkg::FLAG_W-1:0];
        light_q = data[dafs_pkg::FLAG_LIGHT_ON];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_tick(input logic [dafs_pkg::NOW_W-1:0] now,
                           input logic [dafs_pkg::DAY_W-1:0] day,
                           input logic [dafs_pkg::WDAY_W-1:0] wd);
    tick_t tk;
    tk.now = now;
    tk.day = day;
    tk.wd  = wd;
    ticks_to_send.push_back(tk);
    pushed_cnt++;
  endtask

  task automatic push_clock();
    push_tick(cur_now, dafs_pkg::DAY_W'(cur_day), dafs_pkg::WDAY_W'(cur_wd));
  endtask

  // move the stimulus clock forward, rolling the weekday at midnight
  task automatic advance(input longint delta);
    longint sum;
    cur_now = cur_now + dafs_pkg::NOW_W'(delta);
    sum     = cur_day + delta;
    while (sum >= dafs_pkg::DAY_MS) begin
      sum    = sum - dafs_pkg::DAY_MS;
      cur_wd = (cur_wd == 6) ? 0 : cur_wd + 1;
    end
    cur_day = int'(sum);
  endtask

  // distance from the stimulus clock to the next configured daily time
  function automatic longint next_feed_gap();
    logic [dafs_pkg::DAY_W-1:0] d;
    logic [dafs_pkg::DAY_W-1:0] t;
    d = day_clip(dafs_pkg::DAY_W'(cur_day));
    for (int i = 0; i < dafs_pkg::FEED_SLOTS; i++) begin
      t = day_clip(time_r[i]);
      if (i < cnt_r && t > d) return t - d;
    end
    return dafs_pkg::DAY_MS - d + day_clip(time_r[0]);
  endfunction

  // jump to the next daily time with an offset in ms
  task automatic feed_hop(input int off);
    longint gap;
    gap = next_feed_gap() + off;
    if (gap < 0) gap = 0;
    advance(gap);
    push_clock();
  endtask

  // mostly coherent clock ticks, some hops to feed times, some noise
  task automatic random_tick();
    int unsigned pick;
    logic [31:0] a;
    logic [31:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      a = $urandom;
      b = $urandom;
      push_tick(a, b[dafs_pkg::DAY_W-1:0], b[31:29]);
    end else if (pick < 35) begin
      feed_hop(int'($urandom_range(0, 4)) - 2);
    end else begin
      if (pick < 45) advance($urandom_range(0, 90000000));
      else if (pick < 75) advance($urandom_range(1, 3));
      else advance($urandom_range(1, 2500));
      push_clock();
    end
  endtask

  // random register settings for one phase
  task automatic random_setup(input bit every);
    logic [31:0]                w;
    logic [dafs_pkg::DAY_W-1:0] tv [dafs_pkg::FEED_SLOTS];
    logic [dafs_pkg::DAY_W-1:0] tmp;
    bit                         sorted_set;
    int unsigned                pick;
    // slot count, mostly legal
    w = $urandom;
    w[dafs_pkg::CNT_W-1:0] = dafs_pkg::CNT_W'(($urandom_range(0, 3) != 0) ?
                             $urandom_range(1, 4) : $urandom_range(0, 7));
    if (every || $urandom_range(0, 4) != 0)
      write_reg(dafs_pkg::REG_FEED_COUNT, w[dafs_pkg::CDAT_W-1:0]);
    // daily times, sorted in range or raw 27-bit values
    sorted_set = ($urandom_range(0, 9) < 7);
    for (int i = 0; i < dafs_pkg::FEED_SLOTS; i++) begin
      w     = $urandom;
      tv[i] = sorted_set ? dafs_pkg::DAY_W'($urandom_range(0, dafs_pkg::DAY_MAX)) :
                           w[dafs_pkg::DAY_W-1:0];
    end
    if (sorted_set) begin
      for (int i = 0; i < dafs_pkg::FEED_SLOTS - 1; i++) begin
        for (int j = 0; j < dafs_pkg::FEED_SLOTS - 1 - i; j++) begin
          if (tv[j] > tv[j+1]) begin
            tmp     = tv[j];
            tv[j]   = tv[j+1];
            tv[j+1] = tmp;
          end
        end
      end
    end
    for (int i = 0; i < dafs_pkg::FEED_SLOTS; i++) begin
      if (every || $urandom_range(0, 4) != 0)
        write_reg(dafs_pkg::CIDX_W'(dafs_pkg::REG_TIME_ONE + i), tv[i]);
    end
    // feeding length, mostly short
    pick = $urandom_range(0, 9);
    w = $urandom;
    case (pick)
      0: w[dafs_pkg::SEC_W-1:0] = 16'hFFFF;
      1: w[dafs_pkg::SEC_W-1:0] = dafs_pkg::SEC_W'($urandom_range(0, 20));
      default: w[dafs_pkg::SEC_W-1:0] = dafs_pkg::SEC_W'($urandom_range(0, 5));
    endcase
    if (every || $urandom_range(0, 4) != 0)
      write_reg(dafs_pkg::REG_FEED_SECONDS, w[dafs_pkg::CDAT_W-1:0]);
    w = $urandom;
    if (every || $urandom_range(0, 4) != 0)
      write_reg(dafs_pkg::REG_WEEKDAY_MASK, w[dafs_pkg::CDAT_W-1:0]);
    // mode flags, schedule mostly enabled
    w = $urandom;
    if ($urandom_range(0, 4) != 0) w[dafs_pkg::FLAG_SCHED_EN] = 1'b1;
    if (every || $urandom_range(0, 4) != 0)
      write_reg(dafs_pkg::REG_MODE_FLAGS, w[dafs_pkg::CDAT_W-1:0]);
  endtask

  // wait until every item is taken and every result is back
  task automatic drain_block();
    @(negedge clk);
    while (taken_cnt != pushed_cnt || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // run limit
  always @(posedge clk) begin
    cyc++;
    if (cyc >= RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result check, then prediction of the item taken at this edge
  always @(posedge clk) begin
    feed_res_t want;
    feed_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_servo_on, out_light_on, out_feed_started, out_feed_finished, out_wait_left};
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result item, expected none, actual %h", $time, got);
      end else begin
        want = due_results.pop_front();
        check_field("servo_on", 32'(want.servo), 32'(got.servo));
        check_field("light_on", 32'(want.light), 32'(got.light));
        check_field("feed_started", 32'(want.started), 32'(got.started));
        check_field("feed_finished", 32'(want.finished), 32'(got.finished));
        check_field("wait_left", 32'(want.wait_left), 32'(got.wait_left));
      end
    end
    in_took = in_valid && !in_stall;
    if (in_took) begin
      due_results.push_back(step_schedule({in_now_ms, in_day_ms, in_weekday}));
      taken_cnt++;
    end
  end

  // item driver with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!calm && ((cyc / 170) % 3 != 0) && ticks_to_send.size() != 0 &&
                   $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (ticks_to_send.size() != 0) begin
        next_tick = ticks_to_send.pop_front();
        in_now_ms  <= next_tick.now;
        in_day_ms  <= next_tick.day;
        in_weekday <= next_tick.wd;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall: random bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (calm || ((cyc / 230) % 3 == 0)) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // test sequence
  initial begin
    reset_model();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: first tick only computes the wait, then one feeding
    cur_now = '0;
    cur_day = 0;
    cur_wd  = 0;
    push_clock();
    feed_hop(-1);
    feed_hop(0);
    advance(2000);
    push_clock();
    advance(1);
    push_clock();
    drain_block();

    // longest feeding, four slots, all flags: trigger while feeding, count wraps
    write_reg(dafs_pkg::REG_FEED_SECONDS, 27'hFFFF);
    write_reg(dafs_pkg::REG_FEED_COUNT, 27'd4);
    write_reg(dafs_pkg::REG_TIME_ONE, 27'd0);
    write_reg(dafs_pkg::REG_TIME_TWO, 27'd3600000);
    write_reg(dafs_pkg::REG_TIME_THREE, 27'd7200000);
    write_reg(dafs_pkg::REG_TIME_FOUR, dafs_pkg::DAY_MAX);
    write_reg(dafs_pkg::REG_WEEKDAY_MASK, 27'h7F);
    write_reg(dafs_pkg::REG_MODE_FLAGS, 27'hF);
    cur_now = 32'hFFFF_FF00;
    cur_day = 0;
    cur_wd  = 6;
    push_clock();
    feed_hop(0);
    feed_hop(-1);
    feed_hop(0);
    advance(3);
    push_clock();
    feed_hop(0);
    drain_block();

    // schedule off and bad slot count: wait frozen, running feeding still ends
    write_reg(dafs_pkg::REG_MODE_FLAGS, 27'd0);
    write_reg(dafs_pkg::REG_FEED_COUNT, 27'd0);
    cur_now = 32'hFFFF_FFFF;
    push_clock();
    advance(70000000);
    push_clock();
    drain_block();

    // clamped times, calendar blocking, weekday seven, zero-length feeding
    write_reg(dafs_pkg::REG_FEED_SECONDS, 27'd0);
    write_reg(dafs_pkg::REG_WEEKDAY_MASK, 27'd0);
    write_reg(dafs_pkg::REG_MODE_FLAGS, 27'b1101);
    write_reg(dafs_pkg::REG_FEED_COUNT, 27'd1);
    write_reg(dafs_pkg::REG_TIME_ONE, 27'h7FF_FFFF);
    cur_now = 32'h8000_0000;
    cur_day = dafs_pkg::DAY_MAX;
    cur_wd  = 3;
    push_tick(cur_now, 27'h7FF_FFFF, 3'd7);
    advance(dafs_pkg::DAY_MS);
    push_clock();
    advance(dafs_pkg::DAY_MS);
    push_tick(cur_now, dafs_pkg::DAY_W'(cur_day), 3'd7);
    advance(1);
    push_clock();
    drain_block();

    // random phases, each with its own settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1) calm = 1'b1;
      random_setup(p == 0);
      if ($urandom_range(0, 2) == 0) cur_now = 32'hFFFF_FFFF - $urandom_range(0, 50000000);
      if (p == 2) hold_ask++;
      for (int k = 0; k < PHASE_TICKS; k++) random_tick();
      drain_block();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
